// ===== design/lbs_pkg.sv =====
// Shared constants, codes and control structs of the light map box smoother.
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int unsigned DefMaxMapSize  = 1024;
  localparam int unsigned DefChannelBits = 16;

  localparam int unsigned MapSizeW   = 11;
  localparam int unsigned PassCountW = 2;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 11;

  localparam logic [MapSizeW-1:0]   MapSizeRst   = MapSizeW'(256);
  localparam logic [PassCountW-1:0] PassCountRst = PassCountW'(2);

  localparam logic [CfgIdxW-1:0] RegMapSize   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegPassCount = CfgIdxW'(1);

  typedef enum logic [2:0] {
    DIV1,
    DIV2,
    DIV3,
    DIV4,
    DIV6,
    DIV9
  } div_e;

  typedef struct packed {
    logic clr;
    logic rd;
    logic upd;
    logic col;
    logic sum;
    logic mul;
    logic fin;
  } pass_cmd_t;

  typedef struct packed {
    logic tail;
    logic emit;
    logic last;
  } pass_stat_t;

  typedef struct packed {
    pass_cmd_t p1;
    pass_cmd_t p2;
    logic      p2_from_p1;
    logic      out_load;
    logic      out_sel;
    logic      in_ready;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic       in_drain;
    logic       two;
    logic       cfg_clr;
    logic       out_free;
    pass_stat_t p1;
    pass_stat_t p2;
  } ctrl_stat_t;

endpackage

// ===== design/lbs_pass.sv =====
// One smoothing pass: line stores, 3x3 window, position counters and averaging datapath.
`timescale 1ns / 1ps

module lbs_pass import lbs_pkg::*; #(
  parameter int unsigned MAX_MAP_SIZE = DefMaxMapSize,
  parameter int unsigned CHANNEL_BITS = DefChannelBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pass_cmd_t                            cmd_i,
  input  logic [$clog2(MAX_MAP_SIZE+1)-1:0]    w_i,
  input  logic [4*CHANNEL_BITS-1:0]            pix_i,
  output logic [4*CHANNEL_BITS-1:0]            res_o,
  output pass_stat_t                           stat_o
);

  localparam int unsigned XW  = $clog2(MAX_MAP_SIZE);
  localparam int unsigned YW  = $clog2(MAX_MAP_SIZE + 2);
  localparam int unsigned WW  = $clog2(MAX_MAP_SIZE + 1);
  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned SW  = CB + 4;
  localparam int unsigned CSW = CB + 2;
  localparam int unsigned KS  = SW + 4;
  localparam int unsigned PRW = SW + KS + 1;

  localparam longint unsigned M3L = ((64'd1 << KS) + 64'd2) / 64'd3;
  localparam longint unsigned M9L = ((64'd1 << KS) + 64'd8) / 64'd9;

  typedef logic [3:0][CB-1:0] pix_t;
  typedef logic [KS:0]        mul_t;

  localparam mul_t M1 = mul_t'(64'd1 << KS);
  localparam mul_t M3 = mul_t'(M3L);
  localparam mul_t M9 = mul_t'(M9L);

  pix_t bank0 [MAX_MAP_SIZE];
  pix_t bank1 [MAX_MAP_SIZE];
  pix_t rd0_q, rd1_q;
  pix_t win_q [3][3];
  pix_t in_pix;

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic          emit_q, last_q;
  logic [2:0]    rm_q, cm_q, rm, cm;
  logic [XW-1:0] c;
  logic [YW-1:0] r;
  logic          at_end, at_eol;

  logic [3:0][2:0][CSW-1:0] colsum_q;
  logic [3:0][SW-1:0]       total_q;
  div_e                     div_q, div_d;
  logic [3:0][PRW-1:0]      prod_q;
  pix_t                     res_q;

  assign in_pix = pix_t'(pix_i);

  always_comb begin
    c = (x_q == '0) ? XW'(w_i - WW'(1)) : x_q - XW'(1);
    r = (x_q == '0) ? y_q - YW'(2) : y_q - YW'(1);
    rm = {(32'(r) + 32'd1) < 32'(w_i), 1'b1, r != '0};
    cm = {(32'(c) + 32'd1) < 32'(w_i), 1'b1, c != '0};
    at_end = (32'(y_q) == 32'(w_i) + 32'd1) && (x_q == '0);
    at_eol = (32'(x_q) == 32'(w_i) - 32'd1);
    if (at_end) begin
      x_d = '0;
      y_d = '0;
    end else if (at_eol) begin
      x_d = '0;
      y_d = y_q + YW'(1);
    end else begin
      x_d = x_q + XW'(1);
      y_d = y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      emit_q <= 1'b0;
      last_q <= 1'b0;
    end else if (cmd_i.clr) begin
      x_q <= '0;
      y_q <= '0;
    end else if (cmd_i.upd) begin
      x_q    <= x_d;
      y_q    <= y_d;
      emit_q <= (y_q >= YW'(2)) || ((y_q == YW'(1)) && (x_q != '0));
      last_q <= at_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd0_q <= bank0[x_q];
      rd1_q <= bank1[x_q];
    end
    if (cmd_i.upd && !y_q[0]) begin
      bank0[x_q] <= in_pix;
    end
    if (cmd_i.upd && y_q[0]) begin
      bank1[x_q] <= in_pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= y_q[0] ? rd1_q : rd0_q;
      win_q[1][2] <= y_q[0] ? rd0_q : rd1_q;
      win_q[2][2] <= in_pix;
      rm_q        <= rm;
      cm_q        <= cm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.col) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          colsum_q[k][j] <= (rm_q[0] ? CSW'(win_q[0][j][k]) : '0)
                          + CSW'(win_q[1][j][k])
                          + (rm_q[2] ? CSW'(win_q[2][j][k]) : '0);
        end
      end
    end
  end

  always_comb begin
    unique case ({rm_q[0] & rm_q[2], rm_q[0] ^ rm_q[2], cm_q[0] & cm_q[2], cm_q[0] ^ cm_q[2]})
      4'b0000: div_d = DIV1;
      4'b0001: div_d = DIV2;
      4'b0010: div_d = DIV3;
      4'b0100: div_d = DIV2;
      4'b0101: div_d = DIV4;
      4'b0110: div_d = DIV6;
      4'b1000: div_d = DIV3;
      4'b1001: div_d = DIV6;
      4'b1010: div_d = DIV9;
      default: div_d = DIV1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      for (int k = 0; k < 4; k++) begin
        total_q[k] <= (cm_q[0] ? SW'(colsum_q[k][0]) : '0)
                    + SW'(colsum_q[k][1])
                    + (cm_q[2] ? SW'(colsum_q[k][2]) : '0);
      end
      div_q <= div_d;
    end
  end

  logic [3:0][SW-1:0] opnd;
  mul_t               mval;

  always_comb begin
    unique case (div_q)
      DIV2:    mval = M1;
      DIV3:    mval = M3;
      DIV4:    mval = M1;
      DIV6:    mval = M3;
      DIV9:    mval = M9;
      default: mval = M1;
    endcase
    for (int k = 0; k < 4; k++) begin
      unique case (div_q)
        DIV2:    opnd[k] = total_q[k] >> 1;
        DIV4:    opnd[k] = total_q[k] >> 2;
        DIV6:    opnd[k] = total_q[k] >> 1;
        default: opnd[k] = total_q[k];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= PRW'(opnd[k]) * PRW'(mval);
      end
    end
    if (cmd_i.fin) begin
      for (int k = 0; k < 4; k++) begin
        res_q[k] <= prod_q[k][KS +: CB];
      end
    end
  end

  assign res_o       = res_q;
  assign stat_o.tail = 32'(y_q) >= 32'(w_i);
  assign stat_o.emit = emit_q;
  assign stat_o.last = last_q;

endmodule

// ===== design/lbs_ctrl.sv =====
// Sequencing state machine: routes words through one or two passes and loads the output.
`timescale 1ns / 1ps

module lbs_ctrl import lbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_UPD  = 9'b000000100,
    S_COL  = 9'b000001000,
    S_SUM  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_FIN  = 9'b001000000,
    S_DEC  = 9'b010000000,
    S_HOLD = 9'b100000000
  } state_e;

  state_e    state_q, state_d;
  logic      cur_q, cur_d;
  logic      src_q, src_d;
  logic      osel_q, osel_d;
  pass_cmd_t step;
  logic      load;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    src_d   = src_q;
    osel_d  = osel_q;
    load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid) begin
          if (!stat_i.in_drain || stat_i.p1.tail) begin
            cur_d   = 1'b0;
            state_d = S_RD;
          end else if (stat_i.two && stat_i.p2.tail) begin
            cur_d   = 1'b1;
            src_d   = 1'b0;
            state_d = S_RD;
          end
        end
      end
      S_RD:  state_d = S_UPD;
      S_UPD: state_d = S_COL;
      S_COL: state_d = S_SUM;
      S_SUM: state_d = S_MUL;
      S_MUL: state_d = S_FIN;
      S_FIN: state_d = S_DEC;
      S_DEC: begin
        if (!cur_q) begin
          if (!stat_i.p1.emit) begin
            state_d = S_IDLE;
          end else if (stat_i.two) begin
            cur_d   = 1'b1;
            src_d   = 1'b1;
            state_d = S_RD;
          end else begin
            osel_d  = 1'b0;
            state_d = S_HOLD;
          end
        end else begin
          osel_d  = 1'b1;
          state_d = stat_i.p2.emit ? S_HOLD : S_IDLE;
        end
      end
      S_HOLD: begin
        if (stat_i.out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= 1'b0;
      src_q   <= 1'b0;
      osel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      src_q   <= src_d;
      osel_q  <= osel_d;
    end
  end

  always_comb begin
    step     = '0;
    step.rd  = (state_q == S_RD);
    step.upd = (state_q == S_UPD);
    step.col = (state_q == S_COL);
    step.sum = (state_q == S_SUM);
    step.mul = (state_q == S_MUL);
    step.fin = (state_q == S_FIN);

    cmd_o            = '0;
    cmd_o.p1         = cur_q ? '0 : step;
    cmd_o.p2         = cur_q ? step : '0;
    cmd_o.p1.clr     = stat_i.cfg_clr;
    cmd_o.p2.clr     = stat_i.cfg_clr;
    cmd_o.p2_from_p1 = src_q;
    cmd_o.out_load   = load;
    cmd_o.out_sel    = osel_q;
    cmd_o.in_ready   = (state_q == S_IDLE);
  end

endmodule

// ===== design/lightmap_box_smoother_top.sv =====
// Top level of the light map box smoother: ports, configuration, word capture and output register.
// Words are taken one at a time: a new word is accepted only once the sequencer is back in idle,
// after all passes of the previous word and any output stall. A drain word that neither pass
// still needs is accepted and ignored. Each pass sequencer steps through read, update, column
// sum, sum, multiply, finish and decide.
// Reset: asynchronous active low; clears positions, sequencer and output valid, and loads
// map_size 256 and pass_count 2. Line stores and windows keep contents until overwritten.
`timescale 1ns / 1ps

module lightmap_box_smoother_top import lbs_pkg::*; #(
  parameter int unsigned MAX_MAP_SIZE = DefMaxMapSize,
  parameter int unsigned CHANNEL_BITS = DefChannelBits
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // red, green, blue, alpha from bit 0 up, zero padded
  input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // operation: 0 pixel, 1 drain
  input  logic                                      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // out_red, out_green, out_blue, out_alpha from bit 0 up, zero padded
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]       m_axis_tdata,
  output logic                                      m_axis_tlast,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]                        cfg_index_i,
  input  logic [CfgDataW-1:0]                       cfg_data_i
);

  localparam int unsigned PW  = 4 * CHANNEL_BITS;
  localparam int unsigned TDW = ((PW + 7) / 8) * 8;
  localparam int unsigned WW  = $clog2(MAX_MAP_SIZE + 1);

  logic [MapSizeW-1:0]   map_size_q;
  logic [PassCountW-1:0] pass_count_q;
  logic [WW-1:0]         w;
  logic                  cfg_hit;

  logic [PW-1:0] item_q, p1_res, p2_res, p2_pix, out_data_q;
  logic          out_valid_q, out_last_q;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  pass_stat_t p1_stat, p2_stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i &&
                       ((cfg_index_i == RegMapSize) || (cfg_index_i == RegPassCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q   <= MapSizeRst;
      pass_count_q <= PassCountRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegMapSize) begin
        map_size_q <= MapSizeW'(cfg_data_i);
      end
      if (cfg_index_i == RegPassCount) begin
        pass_count_q <= PassCountW'(cfg_data_i);
      end
    end
  end

  always_comb begin
    priority if (map_size_q == '0) begin
      w = WW'(1);
    end else if (32'(map_size_q) > 32'(MAX_MAP_SIZE)) begin
      w = WW'(MAX_MAP_SIZE);
    end else begin
      w = WW'(map_size_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= s_axis_tuser ? '0 : s_axis_tdata[PW-1:0];
    end
  end

  assign stat.in_valid = s_axis_tvalid;
  assign stat.in_drain = s_axis_tuser;
  assign stat.two      = pass_count_q >= PassCountW'(2);
  assign stat.cfg_clr  = cfg_hit;
  assign stat.out_free = !out_valid_q || m_axis_tready;
  assign stat.p1       = p1_stat;
  assign stat.p2       = p2_stat;

  lbs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lbs_pass #(
    .MAX_MAP_SIZE (MAX_MAP_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_pass_one (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd.p1),
    .w_i    (w),
    .pix_i  (item_q),
    .res_o  (p1_res),
    .stat_o (p1_stat)
  );

  assign p2_pix = cmd.p2_from_p1 ? p1_res : item_q;

  lbs_pass #(
    .MAX_MAP_SIZE (MAX_MAP_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_pass_two (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd.p2),
    .w_i    (w),
    .pix_i  (p2_pix),
    .res_o  (p2_res),
    .stat_o (p2_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_data_q <= cmd.out_sel ? p2_res : p1_res;
      out_last_q <= cmd.out_sel ? p2_stat.last : p1_stat.last;
    end
  end

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDW'(out_data_q);
  assign m_axis_tlast  = out_last_q;

endmodule
